>>> sv/mcfc_pkg.sv
// shared types, register codes and reset values for the mohr-coulomb failure check
package mcfc_pkg;

    localparam int STRESS_WIDTH_DEF   = 32;
    localparam int COEF_FRAC_BITS_DEF = 14;
    localparam int ADDR_WIDTH         = 5;
    localparam int DATA_WIDTH         = 32;

    typedef enum logic [1:0] {
        CMD_PARTICLE = 2'd0,
        CMD_PAIR     = 2'd1,
        CMD_BRIDGE   = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_INTACT  = 2'd0,
        KIND_TENSILE = 2'd1,
        KIND_SHEAR   = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_COHESION = 3'd0,
        REG_TENSILE  = 3'd1,
        REG_SLOPE    = 3'd2,
        REG_SINE     = 3'd3,
        REG_COSINE   = 3'd4,
        REG_PAIR_W   = 3'd5,
        REG_BRIDGE_W = 3'd6,
        REG_SPARE    = 3'd7
    } reg_idx_t;

    localparam logic [15:0] SINE_RST     = 16'h4000;
    localparam logic [14:0] PAIR_W_RST   = 15'h2000;
    localparam logic [14:0] BRIDGE_W_RST = 15'h2000;

    typedef struct packed {
        logic [30:0] cohesion;
        logic [30:0] tensile_strength;
        logic [17:0] friction_slope;
        logic [15:0] plane_sine;
        logic [15:0] plane_cosine;
        logic [14:0] pair_weight;
        logic [14:0] bridge_weight;
    } cfg_t;

    typedef struct packed {
        cmd_t cmd;
        logic kill;
    } ctrl_t;

endpackage

>>> sv/mcfc_regs.sv
// apb configuration register file
module mcfc_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mcfc_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [mcfc_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [mcfc_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                             pready,
    output mcfc_pkg::cfg_t                   cfg
);

    mcfc_pkg::cfg_t   cfg_reg;
    mcfc_pkg::reg_idx_t idx;
    logic             wr;

    assign idx    = mcfc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cohesion         <= '0;
            cfg_reg.tensile_strength <= '0;
            cfg_reg.friction_slope   <= '0;
            cfg_reg.plane_sine       <= mcfc_pkg::SINE_RST;
            cfg_reg.plane_cosine     <= '0;
            cfg_reg.pair_weight      <= mcfc_pkg::PAIR_W_RST;
            cfg_reg.bridge_weight    <= mcfc_pkg::BRIDGE_W_RST;
        end
        else if (wr)
        begin
            unique case (idx)
                mcfc_pkg::REG_COHESION: cfg_reg.cohesion         <= pwdata[30:0];
                mcfc_pkg::REG_TENSILE:  cfg_reg.tensile_strength <= pwdata[30:0];
                mcfc_pkg::REG_SLOPE:    cfg_reg.friction_slope   <= pwdata[17:0];
                mcfc_pkg::REG_SINE:     cfg_reg.plane_sine       <= pwdata[15:0];
                mcfc_pkg::REG_COSINE:   cfg_reg.plane_cosine     <= pwdata[15:0];
                mcfc_pkg::REG_PAIR_W:   cfg_reg.pair_weight      <= pwdata[14:0];
                mcfc_pkg::REG_BRIDGE_W: cfg_reg.bridge_weight    <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            mcfc_pkg::REG_COHESION: prdata = {1'b0, cfg_reg.cohesion};
            mcfc_pkg::REG_TENSILE:  prdata = {1'b0, cfg_reg.tensile_strength};
            mcfc_pkg::REG_SLOPE:    prdata = {14'd0, cfg_reg.friction_slope};
            mcfc_pkg::REG_SINE:     prdata = {16'd0, cfg_reg.plane_sine};
            mcfc_pkg::REG_COSINE:   prdata = {16'd0, cfg_reg.plane_cosine};
            mcfc_pkg::REG_PAIR_W:   prdata = {17'd0, cfg_reg.pair_weight};
            mcfc_pkg::REG_BRIDGE_W: prdata = {17'd0, cfg_reg.bridge_weight};
            default:                prdata = '0;
        endcase
    end

endmodule

>>> sv/mcfc_blend.sv
// stress selection and weighted blend, three stages
module mcfc_blend
#(
    parameter int STRESS_WIDTH   = mcfc_pkg::STRESS_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = mcfc_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  mcfc_pkg::ctrl_t                in_ctrl,
    input  logic signed [STRESS_WIDTH-1:0] own [3],
    input  logic signed [STRESS_WIDTH-1:0] peer [3],
    input  logic signed [STRESS_WIDTH-1:0] brg [3],
    input  logic [14:0]                    pair_weight,
    input  logic [14:0]                    bridge_weight,
    output logic                           out_valid,
    output mcfc_pkg::ctrl_t                out_ctrl,
    output logic signed [STRESS_WIDTH:0]   s [3]
);

    localparam int SW = STRESS_WIDTH;
    localparam int Q  = COEF_FRAC_BITS;
    localparam int WW = (Q + 2 > 16) ? Q + 2 : 16;
    localparam int PW = SW + Q + 2;
    localparam logic [WW-1:0] ONE = WW'(1) << Q;

    logic signed [SW-1:0] base_reg [3];
    logic signed [SW-1:0] base_next [3];
    logic signed [SW:0]   diff_reg [3];
    logic signed [SW:0]   diff_next [3];
    logic [Q:0]           wn_reg;
    logic [Q:0]           wn_next;
    logic signed [SW-1:0] base2_reg [3];
    logic signed [PW-1:0] prod_reg [3];
    logic signed [SW:0]   s_reg [3];
    logic [2:0]           v_reg;
    mcfc_pkg::ctrl_t      c1_reg, c2_reg, c3_reg;

    logic [WW-1:0] w_ext;
    logic [WW-1:0] w_cl;
    logic [WW-1:0] w_neg;

    always_comb
    begin
        w_ext = (in_ctrl.cmd == mcfc_pkg::CMD_PAIR) ? WW'(pair_weight) : WW'(bridge_weight);
        w_cl  = (w_ext > ONE) ? ONE : w_ext;
        w_neg = ONE - w_cl;
        wn_next = w_neg[Q:0];
    end

    always_comb
    begin
        logic signed [SW:0] sum;
        logic signed [SW:0] avg;
        for (int k = 0; k < 3; k++)
        begin
            sum = (SW+1)'(own[k]) + (SW+1)'(peer[k]);
            avg = sum >>> 1;
            case (in_ctrl.cmd)
                mcfc_pkg::CMD_PAIR:
                begin
                    base_next[k] = own[k];
                    diff_next[k] = (SW+1)'(peer[k]) - (SW+1)'(own[k]);
                end
                mcfc_pkg::CMD_BRIDGE:
                begin
                    base_next[k] = brg[k];
                    diff_next[k] = avg - (SW+1)'(brg[k]);
                end
                default:
                begin
                    base_next[k] = own[k];
                    diff_next[k] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= in_ctrl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            wn_reg <= wn_next;
            for (int k = 0; k < 3; k++)
            begin
                base_reg[k]  <= base_next[k];
                diff_reg[k]  <= diff_next[k];
                base2_reg[k] <= base_reg[k];
                prod_reg[k]  <= PW'(diff_reg[k]) * PW'($signed({1'b0, wn_reg}));
                s_reg[k]     <= (SW+1)'(PW'(base2_reg[k]) + (prod_reg[k] >>> Q));
            end
        end
    end

    assign out_valid = v_reg[2];
    assign out_ctrl  = c3_reg;
    assign s         = s_reg;

endmodule

>>> sv/mcfc_root.sv
// principal radius: squares, sum and one-bit-per-stage square root
module mcfc_root
#(
    parameter int STRESS_WIDTH = mcfc_pkg::STRESS_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  mcfc_pkg::ctrl_t                in_ctrl,
    input  logic signed [STRESS_WIDTH:0]   s [3],
    output logic                           out_valid,
    output mcfc_pkg::ctrl_t                out_ctrl,
    output logic signed [STRESS_WIDTH+3:0] d,
    output logic signed [STRESS_WIDTH+3:0] r
);

    localparam int SW = STRESS_WIDTH;
    localparam int WD = SW + 4;
    localparam int K  = (SW > 31) ? SW - 31 : 0;
    localparam int AW = (SW > 31) ? 32 : SW + 1;
    localparam int XW = 2 * AW + 1;
    localparam int NS = AW + 1;

    logic                 v4_reg, v5_reg, v6_reg;
    mcfc_pkg::ctrl_t      c4_reg, c5_reg, c6_reg;
    logic signed [WD-1:0] d4_reg, d5_reg, d6_reg;
    logic [AW-1:0]        a_reg, b_reg;
    logic [AW-1:0]        a_next, b_next;
    logic [2*AW-1:0]      asq_reg, bsq_reg;
    logic [XW-1:0]        x6_reg;

    logic                 sv_reg [NS];
    mcfc_pkg::ctrl_t      sc_reg [NS];
    logic signed [WD-1:0] sd_reg [NS];
    logic [XW-1:0]        sx_reg [NS];
    logic [XW-1:0]        sr_reg [NS];

    always_comb
    begin
        logic signed [WD-1:0] dif;
        logic [WD-1:0]        mag;
        logic [WD-1:0]        sh;
        dif = WD'(s[0]) - WD'(s[1]);
        mag = dif[WD-1] ? WD'(-dif) : WD'(dif);
        mag = mag >> K;
        a_next = mag[AW-1:0];
        sh = s[2][SW] ? WD'(-WD'(s[2])) : WD'(s[2]);
        sh = (sh << 1) >> K;
        b_next = sh[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4_reg  <= in_ctrl;
            c5_reg  <= c4_reg;
            c6_reg  <= c5_reg;
            d4_reg  <= WD'(s[0]) + WD'(s[1]);
            d5_reg  <= d4_reg;
            d6_reg  <= d5_reg;
            a_reg   <= a_next;
            b_reg   <= b_next;
            asq_reg <= a_reg * a_reg;
            bsq_reg <= b_reg * b_reg;
            x6_reg  <= XW'(asq_reg) + XW'(bsq_reg);
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_sqrt
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (NS - 1 - i));
        logic [XW-1:0]        x_prev, r_prev, trial, x_next, r_next;
        logic                 v_prev;
        mcfc_pkg::ctrl_t      c_prev;
        logic signed [WD-1:0] d_prev;

        if (i == 0)
        begin : g_first
            assign x_prev = x6_reg;
            assign r_prev = '0;
            assign v_prev = v6_reg;
            assign c_prev = c6_reg;
            assign d_prev = d6_reg;
        end
        else
        begin : g_rest
            assign x_prev = sx_reg[i-1];
            assign r_prev = sr_reg[i-1];
            assign v_prev = sv_reg[i-1];
            assign c_prev = sc_reg[i-1];
            assign d_prev = sd_reg[i-1];
        end

        always_comb
        begin
            trial = r_prev + BIT;
            if (x_prev >= trial)
            begin
                x_next = x_prev - trial;
                r_next = (r_prev >> 1) + BIT;
            end
            else
            begin
                x_next = x_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[i] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sx_reg[i] <= x_next;
                sr_reg[i] <= r_next;
                sc_reg[i] <= c_prev;
                sd_reg[i] <= d_prev;
            end
        end
    end

    assign out_valid = sv_reg[NS-1];
    assign out_ctrl  = sc_reg[NS-1];
    assign d         = sd_reg[NS-1];
    assign r         = WD'(sr_reg[NS-1][AW:0]) << K;

endmodule

>>> sv/mcfc_eval.sv
// plane projection, shear and tension tests, result register
module mcfc_eval
#(
    parameter int STRESS_WIDTH   = mcfc_pkg::STRESS_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = mcfc_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  mcfc_pkg::ctrl_t                in_ctrl,
    input  logic signed [STRESS_WIDTH+3:0] d,
    input  logic signed [STRESS_WIDTH+3:0] r,
    input  mcfc_pkg::cfg_t                 cfg,
    output logic                           out_valid,
    output logic [1:0]                     failure_kind,
    output logic                           cut_bond
);

    localparam int SW = STRESS_WIDTH;
    localparam int Q  = COEF_FRAC_BITS;
    localparam int WD = SW + 4;
    localparam int LW = SW + Q + 48;

    logic                 v1_reg, v2_reg, v3_reg, out_valid_reg;
    mcfc_pkg::ctrl_t      c1_reg, c2_reg, c3_reg;
    logic signed [WD+15:0] pc_reg;
    logic signed [WD+16:0] ps_reg;
    logic signed [WD-1:0] d1_reg;
    logic                 t1_reg, t2_reg, t3_reg;
    logic signed [WD-1:0] n2_reg;
    logic signed [WD-1:0] lhs2_reg, lhs3_reg;
    logic                 neg3_reg;
    logic signed [WD+18:0] nf3_reg;
    mcfc_pkg::kind_t      kind_reg, kind_next;
    logic                 cut_reg, cut_next;

    logic [15:0]          sin_abs;
    logic                 tens_next;
    logic signed [LW-1:0] n2_w, lhs_w, rhs_w, two_t, two_c;
    logic                 shear;

    always_comb
    begin
        sin_abs   = cfg.plane_sine[15] ? 16'(-cfg.plane_sine) : cfg.plane_sine;
        two_t     = LW'($signed({2'b00, cfg.tensile_strength, 1'b0}));
        tens_next = (LW'(d) + LW'(r)) >= two_t;
        n2_w      = LW'(d1_reg) - (LW'(pc_reg) >>> Q);
        lhs_w     = LW'(ps_reg) >>> Q;
        two_c     = LW'($signed({2'b00, cfg.cohesion, 1'b0}));
        rhs_w     = two_c - (LW'(nf3_reg) >>> Q);
        if (rhs_w < 0)
        begin
            rhs_w = -rhs_w;
        end
        shear = LW'(lhs3_reg) >= rhs_w;
    end

    always_comb
    begin
        kind_next = mcfc_pkg::KIND_INTACT;
        cut_next  = 1'b0;
        if (!c3_reg.kill)
        begin
            if (c3_reg.cmd == mcfc_pkg::CMD_PARTICLE)
            begin
                if (shear)
                    kind_next = mcfc_pkg::KIND_SHEAR;
                else if (t3_reg)
                    kind_next = mcfc_pkg::KIND_TENSILE;
            end
            else if (shear && neg3_reg)
            begin
                kind_next = mcfc_pkg::KIND_SHEAR;
                cut_next  = 1'b1;
            end
            else if (t3_reg)
            begin
                kind_next = mcfc_pkg::KIND_TENSILE;
                cut_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg   <= in_ctrl;
            c2_reg   <= c1_reg;
            c3_reg   <= c2_reg;
            pc_reg   <= (WD+16)'(r) * (WD+16)'($signed(cfg.plane_cosine));
            ps_reg   <= (WD+17)'(r) * (WD+17)'($signed({1'b0, sin_abs}));
            d1_reg   <= d;
            t1_reg   <= tens_next;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            n2_reg   <= WD'(n2_w);
            lhs2_reg <= WD'(lhs_w);
            lhs3_reg <= lhs2_reg;
            neg3_reg <= n2_reg[WD-1];
            nf3_reg  <= (WD+19)'(n2_reg) * (WD+19)'($signed({1'b0, cfg.friction_slope}));
            kind_reg <= kind_next;
            cut_reg  <= cut_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign failure_kind = kind_reg;
    assign cut_bond     = cut_reg;

endmodule

>>> sv/mohr_coulomb_failure_check.sv
// top level of the mohr-coulomb failure check
// One stress check enters per clock cycle while item_stall is low, and each
// transaction yields exactly one result. The square root resolves one root bit
// per stage over 33 stages at widths above 31 bits; the blend takes three stages,
// squaring three, projection and tests four. When a result is stalled the whole
// pipeline holds, so item_stall follows result_stall while a result is waiting.
// Configuration is to be written over the apb port by the user only while idle; the block does not enforce it.
module mohr_coulomb_failure_check
#(
    parameter int STRESS_WIDTH   = mcfc_pkg::STRESS_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = mcfc_pkg::COEF_FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mcfc_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [mcfc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [mcfc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                            pready,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [1:0]                      command,
    input  logic signed [STRESS_WIDTH-1:0]  own_xx,
    input  logic signed [STRESS_WIDTH-1:0]  own_yy,
    input  logic signed [STRESS_WIDTH-1:0]  own_xy,
    input  logic signed [STRESS_WIDTH-1:0]  peer_xx,
    input  logic signed [STRESS_WIDTH-1:0]  peer_yy,
    input  logic signed [STRESS_WIDTH-1:0]  peer_xy,
    input  logic signed [STRESS_WIDTH-1:0]  bridge_xx,
    input  logic signed [STRESS_WIDTH-1:0]  bridge_yy,
    input  logic signed [STRESS_WIDTH-1:0]  bridge_xy,
    input  logic                            unbreakable,
    input  logic                            bond_connected,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [1:0]                      failure_kind,
    output logic                            cut_bond
);

    mcfc_pkg::cfg_t  cfg;
    mcfc_pkg::ctrl_t in_ctrl, b_ctrl, r_ctrl;
    logic            en, b_valid, r_valid;
    logic signed [STRESS_WIDTH-1:0] own [3];
    logic signed [STRESS_WIDTH-1:0] peer [3];
    logic signed [STRESS_WIDTH-1:0] brg [3];
    logic signed [STRESS_WIDTH:0]   s [3];
    logic signed [STRESS_WIDTH+3:0] d, r;

    assign en         = !(result_valid && result_stall);
    assign item_stall = !en;

    assign own  = '{own_xx, own_yy, own_xy};
    assign peer = '{peer_xx, peer_yy, peer_xy};
    assign brg  = '{bridge_xx, bridge_yy, bridge_xy};

    always_comb
    begin
        in_ctrl.cmd  = mcfc_pkg::cmd_t'(command);
        in_ctrl.kill = unbreakable || (command == mcfc_pkg::CMD_NONE)
                       || ((command != mcfc_pkg::CMD_PARTICLE) && !bond_connected);
    end

    mcfc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcfc_blend #(
        .STRESS_WIDTH   (STRESS_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_blend
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (item_valid),
        .in_ctrl       (in_ctrl),
        .own           (own),
        .peer          (peer),
        .brg           (brg),
        .pair_weight   (cfg.pair_weight),
        .bridge_weight (cfg.bridge_weight),
        .out_valid     (b_valid),
        .out_ctrl      (b_ctrl),
        .s             (s)
    );

    mcfc_root #(
        .STRESS_WIDTH (STRESS_WIDTH)
    ) u_root
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid),
        .in_ctrl   (b_ctrl),
        .s         (s),
        .out_valid (r_valid),
        .out_ctrl  (r_ctrl),
        .d         (d),
        .r         (r)
    );

    mcfc_eval #(
        .STRESS_WIDTH   (STRESS_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_eval
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (r_valid),
        .in_ctrl      (r_ctrl),
        .d            (d),
        .r            (r),
        .cfg          (cfg),
        .out_valid    (result_valid),
        .failure_kind (failure_kind),
        .cut_bond     (cut_bond)
    );

endmodule
